// ----- rtl/srtf_pkg.sv -----
// Shared constants for the SRTF tick scheduler.
// No dependencies.
`default_nettype none
package srtf_pkg;
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_TICK = 1'b1;
    localparam int unsigned REG_PROCESS_COUNT = 0;
endpackage
`default_nettype wire

// ----- rtl/srtf_tick_scheduler.sv -----
// SRTF tick scheduler: one load or tick item in, one or two result items out. Slot state
// (arrival, remaining, waiting) lives in one synchronous memory with a registered read;
// a tick makes two passes over the in-use slots, one slot per cycle: a scan pass that reads
// each entry and tracks the best candidate, and an update pass that reads each entry again
// and writes back waiting and remaining. A tick runs the scan pass, a decide state, the
// update pass (skipped when nothing is ready) and an output state that posts the result;
// the next item is accepted only once that result has been taken. A final completion posts
// a second item that closes the last segment. A load or an all-done tick posts its result
// straight from idle. Done marks sit in flip-flops, cleared by reset.
// Configuration: process_count at address 0. No clearing pass is needed.
// Depends on srtf_pkg.
`default_nettype none
module srtf_tick_scheduler #(
    parameter int MAX_PROCS = 16,
    parameter int TIME_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_action,
    input  wire logic [3:0]  s_slot,
    input  wire logic [15:0] s_arrival,
    input  wire logic [15:0] s_burst,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_idle,
    output logic [3:0]       m_running_slot,
    output logic             m_seg_closed,
    output logic             m_seg_idle,
    output logic [3:0]       m_seg_slot,
    output logic [15:0]      m_seg_begin,
    output logic [15:0]      m_seg_end,
    output logic             m_finished,
    output logic [3:0]       m_finished_slot,
    output logic [15:0]      m_turnaround,
    output logic [15:0]      m_waiting,
    output logic             m_last
);
    import srtf_pkg::*;
    localparam int SW = $clog2(MAX_PROCS);
    localparam int CW = $clog2(MAX_PROCS + 1);
    localparam int TB = TIME_BITS;
    localparam logic [TB-1:0] TMAX = {TB{1'b1}};
    localparam logic [2:0] S_IDLE = 3'd0, S_SCAN = 3'd1, S_DECIDE = 3'd2, S_UPD = 3'd3,
                           S_OUT = 3'd4, S_OUT2 = 3'd5;

    // Memory word: arrival, remaining, waiting.
    logic [3*TB-1:0] mem [MAX_PROCS];
    logic [3*TB-1:0] rd_q;
    logic            we;
    logic [SW-1:0]   waddr, raddr;
    logic [3*TB-1:0] wdata;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rd_q <= mem[raddr];
    end

    logic [4:0]          pcount_reg;
    logic [2:0]          state_reg;
    logic [CW-1:0]       idx_reg;    // issue index
    logic                rvld_reg;   // read data valid this cycle
    logic [SW-1:0]       ridx_reg;   // index of read data
    logic [MAX_PROCS-1:0] done_reg;
    logic [TB-1:0]       now_reg;
    logic                seg_open_reg, seg_own_idle_reg;
    logic [SW-1:0]       seg_owner_reg;
    logic [TB-1:0]       seg_begin_reg;
    logic                have_reg;
    logic [SW-1:0]       pick_reg;
    logic [TB-1:0]       prem_reg, parr_reg;
    logic                outv_reg;
    // result registers
    logic r_idle, r_sc, r_si, r_fin, r_last;
    logic [3:0] r_run, r_ss, r_fs;
    logic [15:0] r_st, r_se, r_ta, r_wt;

    logic [CW-1:0] n_use;
    always_comb begin
        if (pcount_reg == 5'd0) n_use = CW'(1);
        else if (32'(pcount_reg) > MAX_PROCS) n_use = CW'(MAX_PROCS);
        else n_use = CW'(pcount_reg);
    end

    logic [TB-1:0] rarr, rrem, rwt;
    assign rarr = rd_q[3*TB-1:2*TB];
    assign rrem = rd_q[2*TB-1:TB];
    assign rwt  = rd_q[TB-1:0];
    logic rready;
    assign rready = !done_reg[ridx_reg] && rarr <= now_reg && rrem != '0;

    logic [CW-1:0] done_cnt;
    always_comb begin
        done_cnt = '0;
        for (int i = 0; i < MAX_PROCS; i++)
            if (i < 32'(n_use) && done_reg[i]) done_cnt = done_cnt + 1'b1;
    end
    logic all_done_now;
    assign all_done_now = done_cnt >= n_use;

    assign pready = 1'b1;
    assign prdata = {27'd0, pcount_reg};
    assign s_ready = (state_reg == S_IDLE) && !outv_reg;
    assign m_valid = outv_reg;

    logic s_acc, issue_done;
    assign s_acc = s_valid && s_ready;
    assign issue_done = idx_reg >= n_use;

    logic [TB-1:0] now_inc, wt_inc;
    assign now_inc = (now_reg == TMAX) ? TMAX : now_reg + 1'b1;
    assign wt_inc  = (rwt == TMAX) ? TMAX : rwt + 1'b1;

    always_comb begin
        we = 1'b0; waddr = ridx_reg; wdata = rd_q; raddr = idx_reg[SW-1:0];
        if (s_acc && s_action == ACT_LOAD && 32'(s_slot) < MAX_PROCS) begin
            we = 1'b1; waddr = SW'(s_slot);
            wdata = {TB'(s_arrival), (s_burst == 16'd0) ? TB'(1) : TB'(s_burst), TB'(0)};
        end else if (state_reg == S_UPD && rvld_reg && have_reg) begin
            if (ridx_reg == pick_reg) begin
                we = 1'b1; wdata = {rarr, rrem - 1'b1, rwt};
            end else if (rready) begin
                we = 1'b1; wdata = {rarr, rrem, wt_inc};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pcount_reg <= 5'd1; state_reg <= S_IDLE; outv_reg <= 1'b0;
            done_reg <= '0; now_reg <= '0; seg_open_reg <= 1'b0;
            seg_own_idle_reg <= 1'b1; seg_owner_reg <= '0; seg_begin_reg <= '0;
            rvld_reg <= 1'b0; idx_reg <= '0; have_reg <= 1'b0;
        end else begin
            if (psel && penable && pwrite && paddr[2] == 1'b0)
                pcount_reg <= pwdata[4:0];
            if (outv_reg && m_ready) outv_reg <= 1'b0;
            rvld_reg <= 1'b0;
            ridx_reg <= idx_reg[SW-1:0];
            case (state_reg)
                S_IDLE: begin
                    if (s_acc) begin
                        {r_idle, r_run, r_sc, r_si, r_ss, r_st, r_se} <= {1'b1, 4'd0, 2'b0,
                            4'd0, 32'd0};
                        {r_fin, r_fs, r_ta, r_wt, r_last} <= {1'b0, 4'd0, 32'd0, 1'b1};
                        if (s_action == ACT_LOAD) begin
                            if (32'(s_slot) < MAX_PROCS) done_reg[SW'(s_slot)] <= 1'b0;
                            now_reg <= '0; seg_open_reg <= 1'b0; seg_own_idle_reg <= 1'b1;
                            seg_begin_reg <= '0;
                            outv_reg <= 1'b1;
                        end else if (all_done_now) begin
                            outv_reg <= 1'b1;
                        end else begin
                            idx_reg <= '0; have_reg <= 1'b0; state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (!issue_done) begin
                        idx_reg <= idx_reg + 1'b1; rvld_reg <= 1'b1;
                    end
                    if (rvld_reg && rready && (!have_reg || rrem < prem_reg ||
                        (rrem == prem_reg && rarr < parr_reg))) begin
                        have_reg <= 1'b1; pick_reg <= ridx_reg;
                        prem_reg <= rrem; parr_reg <= rarr;
                    end
                    if (issue_done && !rvld_reg) state_reg <= S_DECIDE;
                end
                S_DECIDE: begin
                    r_idle <= !have_reg; r_run <= have_reg ? 4'(pick_reg) : 4'd0;
                    if (!seg_open_reg) begin
                        seg_open_reg <= 1'b1; seg_own_idle_reg <= !have_reg;
                        seg_owner_reg <= pick_reg; seg_begin_reg <= now_reg;
                    end else if ((have_reg == seg_own_idle_reg) ||
                                 (have_reg && pick_reg != seg_owner_reg)) begin
                        r_sc <= 1'b1; r_si <= seg_own_idle_reg;
                        r_ss <= seg_own_idle_reg ? 4'd0 : 4'(seg_owner_reg);
                        r_st <= 16'(seg_begin_reg); r_se <= 16'(now_reg);
                        seg_own_idle_reg <= !have_reg; seg_owner_reg <= pick_reg;
                        seg_begin_reg <= now_reg;
                    end
                    idx_reg <= '0; state_reg <= have_reg ? S_UPD : S_OUT;
                end
                S_UPD: begin
                    if (!issue_done) begin
                        idx_reg <= idx_reg + 1'b1; rvld_reg <= 1'b1;
                    end
                    if (rvld_reg && ridx_reg == pick_reg && rrem == TB'(1)) begin
                        done_reg[pick_reg] <= 1'b1;
                        r_fin <= 1'b1; r_fs <= 4'(pick_reg);
                        r_ta <= 16'(now_inc - rarr); r_wt <= 16'(rwt);
                    end
                    if (issue_done && !rvld_reg) state_reg <= S_OUT;
                end
                S_OUT: begin
                    now_reg <= now_inc;
                    r_last <= !(r_fin && all_done_now);
                    outv_reg <= 1'b1;
                    state_reg <= (r_fin && all_done_now) ? S_OUT2 : S_IDLE;
                end
                S_OUT2: begin
                    if (m_ready) begin
                        outv_reg <= 1'b1;
                        {r_idle, r_run, r_sc, r_si} <= {1'b1, 4'd0, 1'b1, seg_own_idle_reg};
                        r_ss <= seg_own_idle_reg ? 4'd0 : 4'(seg_owner_reg);
                        r_st <= 16'(seg_begin_reg); r_se <= 16'(now_reg);
                        {r_fin, r_fs, r_ta, r_wt, r_last} <= {1'b0, 4'd0, 32'd0, 1'b1};
                        seg_open_reg <= 1'b0; seg_own_idle_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_idle = r_idle; assign m_running_slot = r_run; assign m_seg_closed = r_sc;
    assign m_seg_idle = r_si; assign m_seg_slot = r_ss; assign m_seg_begin = r_st;
    assign m_seg_end = r_se; assign m_finished = r_fin; assign m_finished_slot = r_fs;
    assign m_turnaround = r_ta; assign m_waiting = r_wt; assign m_last = r_last;

    // The input side is closed whenever a tick is in progress.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != S_IDLE |-> !s_ready) else $error("accept during tick");
    // A finish always belongs to a running slot.
    assert property (@(posedge aclk) disable iff (!aresetn)
        outv_reg && r_fin |-> !r_idle) else $error("finish while idle");
    // Hold a waiting result item unchanged until it is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable({m_idle, m_running_slot, m_seg_closed,
            m_seg_idle, m_seg_slot, m_seg_begin, m_seg_end, m_finished, m_finished_slot,
            m_turnaround, m_waiting, m_last})) else $error("result item changed while held");
endmodule
`default_nettype wire

// ----- verif/srtf_tick_scheduler_test.sv -----
// Self-checking testbench for srtf_tick_scheduler: drives load and tick items
// and APB register writes, and checks every result item against its own SRTF predictor.
// Depends on srtf_pkg and the srtf_tick_scheduler RTL.
`default_nettype none
module srtf_tick_scheduler_test;
    import srtf_pkg::*;

    localparam int SLOTS = 16;
    localparam int IDLE_OWNER = SLOTS;
    localparam logic [15:0] TIME_TOP = 16'hFFFF;
    localparam int SETTLE_CYCLES = 60;

    typedef struct packed {
        logic        idle;
        logic [3:0]  running_slot;
        logic        seg_closed;
        logic        seg_idle;
        logic [3:0]  seg_slot;
        logic [15:0] seg_begin;
        logic [15:0] seg_end;
        logic        finished;
        logic [3:0]  finished_slot;
        logic [15:0] turnaround;
        logic [15:0] waiting;
        logic        last;
    } sched_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_action = ACT_LOAD;
    logic [3:0]  s_slot = '0;
    logic [15:0] s_arrival = '0;
    logic [15:0] s_burst = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_idle;
    logic [3:0]  m_running_slot;
    logic        m_seg_closed;
    logic        m_seg_idle;
    logic [3:0]  m_seg_slot;
    logic [15:0] m_seg_begin;
    logic [15:0] m_seg_end;
    logic        m_finished;
    logic [3:0]  m_finished_slot;
    logic [15:0] m_turnaround;
    logic [15:0] m_waiting;
    logic        m_last;

    srtf_tick_scheduler u_top (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready), .s_action(s_action), .s_slot(s_slot),
        .s_arrival(s_arrival), .s_burst(s_burst),
        .m_valid(m_valid), .m_ready(m_ready), .m_idle(m_idle),
        .m_running_slot(m_running_slot), .m_seg_closed(m_seg_closed),
        .m_seg_idle(m_seg_idle), .m_seg_slot(m_seg_slot), .m_seg_begin(m_seg_begin),
        .m_seg_end(m_seg_end), .m_finished(m_finished), .m_finished_slot(m_finished_slot),
        .m_turnaround(m_turnaround), .m_waiting(m_waiting), .m_last(m_last)
    );

    always #2 aclk = ~aclk;

    // Predictor state: a private copy of the scheduler's slot table and timeline.
    logic [15:0] arrival_tab [SLOTS];
    logic [15:0] remain_tab [SLOTS];
    logic [15:0] wait_tab [SLOTS];
    bit          done_tab [SLOTS];
    logic [15:0] sim_now;
    bit          seg_live;
    int          seg_owner;
    logic [15:0] seg_from;
    logic [4:0]  proc_count_reg;

    sched_result_t expected_results[$];
    int  error_count;
    int  items_sent;
    bit  gaps_on;
    int  rx_hold_req;
    int  rx_hold_left;

    function automatic int slots_in_use();
        if (proc_count_reg == 0) return 1;
        if (proc_count_reg > SLOTS) return SLOTS;
        return proc_count_reg;
    endfunction

    function automatic bit slot_ready(int i);
        return !done_tab[i] && arrival_tab[i] <= sim_now && remain_tab[i] != 0;
    endfunction

    function automatic logic [15:0] sat_step(logic [15:0] v);
        return (v == TIME_TOP) ? TIME_TOP : v + 16'd1;
    endfunction

    function automatic int done_in_use();
        int cnt;
        cnt = 0;
        for (int i = 0; i < slots_in_use(); i++)
            if (done_tab[i]) cnt++;
        return cnt;
    endfunction

    // Advance the predictor by one accepted item and queue the results it causes.
    task automatic predict_schedule(input logic act, input logic [3:0] sl,
                                    input logic [15:0] arr, input logic [15:0] bur);
        sched_result_t r;
        int n;
        int pick;
        n = slots_in_use();
        pick = IDLE_OWNER;
        r = '0;
        if (act == ACT_LOAD) begin
            arrival_tab[sl] = arr;
            remain_tab[sl] = (bur == 0) ? 16'd1 : bur;
            wait_tab[sl] = '0;
            done_tab[sl] = 1'b0;
            sim_now = '0;
            seg_live = 1'b0;
            seg_owner = IDLE_OWNER;
            seg_from = '0;
            r.idle = 1'b1;
            r.last = 1'b1;
            expected_results.push_back(r);
            return;
        end
        if (done_in_use() >= n) begin
            r.idle = 1'b1;
            r.last = 1'b1;
            expected_results.push_back(r);
            return;
        end
        for (int i = 0; i < n; i++) begin
            if (!slot_ready(i)) continue;
            if (pick == IDLE_OWNER || remain_tab[i] < remain_tab[pick] ||
                (remain_tab[i] == remain_tab[pick] && arrival_tab[i] < arrival_tab[pick]))
                pick = i;
        end
        // Open a segment on the first tick after a restart; close one on owner change.
        if (!seg_live) begin
            seg_live = 1'b1;
            seg_owner = pick;
            seg_from = sim_now;
        end else if (pick != seg_owner) begin
            r.seg_closed = 1'b1;
            r.seg_idle = (seg_owner == IDLE_OWNER);
            r.seg_slot = r.seg_idle ? 4'd0 : 4'(seg_owner);
            r.seg_begin = seg_from;
            r.seg_end = sim_now;
            seg_owner = pick;
            seg_from = sim_now;
        end
        if (pick != IDLE_OWNER) begin
            for (int i = 0; i < n; i++)
                if (i != pick && slot_ready(i)) wait_tab[i] = sat_step(wait_tab[i]);
            remain_tab[pick] = remain_tab[pick] - 16'd1;
            if (remain_tab[pick] == 0) begin
                done_tab[pick] = 1'b1;
                r.finished = 1'b1;
                r.finished_slot = 4'(pick);
                r.turnaround = sat_step(sim_now) - arrival_tab[pick];
                r.waiting = wait_tab[pick];
            end
            r.running_slot = 4'(pick);
        end else begin
            r.idle = 1'b1;
        end
        sim_now = sat_step(sim_now);
        if (r.finished && done_in_use() >= n) begin
            // Last completion: a second item closes the final segment.
            expected_results.push_back(r);
            r = '0;
            r.idle = 1'b1;
            r.seg_closed = 1'b1;
            r.seg_idle = (seg_owner == IDLE_OWNER);
            r.seg_slot = r.seg_idle ? 4'd0 : 4'(seg_owner);
            r.seg_begin = seg_from;
            r.seg_end = sim_now;
            r.last = 1'b1;
            seg_live = 1'b0;
            seg_owner = IDLE_OWNER;
        end else begin
            r.last = 1'b1;
        end
        expected_results.push_back(r);
    endtask

    // Offer one item and hold it until accepted; valid is only lowered for a gap.
    task automatic send_item(input logic act, input logic [3:0] sl,
                             input logic [15:0] arr, input logic [15:0] bur);
        int gap;
        gap = (gaps_on && $urandom_range(0, 99) < 33) ? $urandom_range(1, 6) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_action <= act;
        s_slot <= sl;
        s_arrival <= arr;
        s_burst <= bur;
        do @(posedge aclk); while (!(s_valid && s_ready));
        predict_schedule(act, sl, arr, bur);
        items_sent++;
    endtask

    task automatic send_tick();
        send_item(ACT_TICK, 4'($urandom), 16'($urandom), 16'($urandom));
    endtask

    // Wait for every expected item, then let the block settle.
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Two-phase APB write; call only with the block drained.
    task automatic write_proc_count(input logic [4:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'(REG_PROCESS_COUNT * 4);
        pwdata <= 32'(val);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        proc_count_reg = val;
        @(posedge aclk);
    endtask

    task automatic check_result();
        sched_result_t want;
        if (expected_results.size() == 0) begin
            $error("result item with nothing expected");
            error_count++;
            return;
        end
        want = expected_results.pop_front();
        if (m_idle !== want.idle) begin
            $error("idle: expected %0d got %0d", want.idle, m_idle); error_count++;
        end
        if (m_running_slot !== want.running_slot) begin
            $error("running_slot: expected %0d got %0d", want.running_slot,
                   m_running_slot); error_count++;
        end
        if (m_seg_closed !== want.seg_closed) begin
            $error("seg_closed: expected %0d got %0d", want.seg_closed, m_seg_closed);
            error_count++;
        end
        if (m_seg_idle !== want.seg_idle) begin
            $error("seg_idle: expected %0d got %0d", want.seg_idle, m_seg_idle);
            error_count++;
        end
        if (m_seg_slot !== want.seg_slot) begin
            $error("seg_slot: expected %0d got %0d", want.seg_slot, m_seg_slot);
            error_count++;
        end
        if (m_seg_begin !== want.seg_begin) begin
            $error("seg_begin: expected %0d got %0d", want.seg_begin, m_seg_begin);
            error_count++;
        end
        if (m_seg_end !== want.seg_end) begin
            $error("seg_end: expected %0d got %0d", want.seg_end, m_seg_end);
            error_count++;
        end
        if (m_finished !== want.finished) begin
            $error("finished: expected %0d got %0d", want.finished, m_finished);
            error_count++;
        end
        if (m_finished_slot !== want.finished_slot) begin
            $error("finished_slot: expected %0d got %0d", want.finished_slot,
                   m_finished_slot); error_count++;
        end
        if (m_turnaround !== want.turnaround) begin
            $error("turnaround: expected %0d got %0d", want.turnaround, m_turnaround);
            error_count++;
        end
        if (m_waiting !== want.waiting) begin
            $error("waiting: expected %0d got %0d", want.waiting, m_waiting);
            error_count++;
        end
        if (m_last !== want.last) begin
            $error("last: expected %0d got %0d", want.last, m_last); error_count++;
        end
    endtask

    // Receiver: random stalls, long hold-offs on request, and the result check.
    always @(posedge aclk) begin
        if (rx_hold_req > 0) begin
            rx_hold_left = rx_hold_req;
            rx_hold_req = 0;
        end
        if (aresetn && m_valid && m_ready) check_result();
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_ready <= 1'b0;
        end else if (gaps_on) begin
            m_ready <= ($urandom_range(0, 99) >= 33);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Directed: write every slot (so no tick ever reads an empty slot), field
    // extremes, zero burst, late arrival, count aliases, completion and all-done ticks.
    task automatic test_directed();
        write_proc_count(5'd16);
        for (int i = 0; i < SLOTS; i++)
            send_item(ACT_LOAD, 4'(i), 16'(i % 3), 16'(i + 1));
        send_item(ACT_LOAD, 4'd15, TIME_TOP, TIME_TOP);
        send_item(ACT_LOAD, 4'd14, 16'd0, 16'd0);
        repeat (4) send_tick();
        drain_results();
        write_proc_count(5'd0);
        send_item(ACT_LOAD, 4'd0, 16'd2, 16'd2);
        repeat (6) send_tick();
        drain_results();
        write_proc_count(5'd31);
        send_item(ACT_LOAD, 4'd3, 16'd0, 16'd1);
        send_tick();
        drain_results();
    endtask

    // Random schedules: load n slots, tick them until all are done or 80 items have gone in, some noise loads.
    task automatic test_random_schedules(input int item_goal);
        int n;
        int ticks;
        logic [4:0] cfg;
        logic [15:0] arr;
        logic [15:0] bur;
        while (items_sent < item_goal) begin
            // A long stretch with no idling on either side in the middle.
            gaps_on = !(items_sent > item_goal / 2 && items_sent < item_goal * 2 / 3);
            n = ($urandom_range(0, 3) == 0) ? SLOTS : $urandom_range(1, 8);
            cfg = 5'(n);
            if (n == 1 && $urandom_range(0, 1)) cfg = 5'd0;
            if (n == SLOTS && $urandom_range(0, 1)) cfg = 5'($urandom_range(17, 31));
            drain_results();
            write_proc_count(cfg);
            for (int i = 0; i < n; i++) begin
                arr = ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8));
                bur = ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
                send_item(ACT_LOAD, 4'(i), arr, bur);
            end
            ticks = 0;
            while (done_in_use() < slots_in_use() && ticks < 80) begin
                if ($urandom_range(0, 29) == 0)
                    send_item(ACT_LOAD, 4'($urandom_range(0, n - 1)),
                              16'($urandom_range(0, 4)), 16'($urandom_range(1, 4)));
                else
                    send_tick();
                ticks++;
            end
            repeat ($urandom_range(0, 2)) send_tick();
        end
    endtask

    // Stall the receiver for a long stretch while ticks keep coming.
    task automatic test_output_stall();
        drain_results();
        write_proc_count(5'd4);
        gaps_on = 1'b0;
        for (int i = 0; i < 4; i++)
            send_item(ACT_LOAD, 4'(i), 16'(i), 16'($urandom_range(2, 9)));
        rx_hold_req = 400;
        repeat (30) send_tick();
        // Sender pauses here until the block has delivered everything.
        drain_results();
        gaps_on = 1'b1;
        repeat (10) send_tick();
        drain_results();
    endtask

    initial begin
        error_count = 0;
        items_sent = 0;
        gaps_on = 1'b1;
        rx_hold_req = 0;
        rx_hold_left = 0;
        for (int i = 0; i < SLOTS; i++) begin
            arrival_tab[i] = '0;
            remain_tab[i] = '0;
            wait_tab[i] = '0;
            done_tab[i] = 1'b0;
        end
        sim_now = '0;
        seg_live = 1'b0;
        seg_owner = IDLE_OWNER;
        seg_from = '0;
        proc_count_reg = 5'd1;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_output_stall();
        test_random_schedules(1050);
        drain_results();
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #8000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire

// ----- sim.f -----
rtl/srtf_pkg.sv
rtl/srtf_tick_scheduler.sv
verif/srtf_tick_scheduler_test.sv
